@@ sv/sro_pkg.sv @@
// Package with the shared types and constants of the sequence reorder buffer.
`timescale 1ns / 1ps

package sro_pkg;

  // Number of slots in the reorder window.
  localparam int unsigned Window = 32;
  // Sequence numbers wrap over the full width of the seq field.
  localparam int unsigned SeqW = 16;
  localparam int unsigned HandleW = 32;
  localparam int unsigned LenW = 16;
  localparam int unsigned WinIdxW = (Window > 1) ? $clog2(Window) : 1;
  // Span of held packets runs from 0 up to Window inclusive.
  localparam int unsigned SpanW = $clog2(Window + 1);

  typedef enum logic {
    OpAdd     = 1'b0,
    OpTimeout = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    KindDeliver   = 3'd0,
    KindHeld      = 3'd1,
    KindOutdated  = 3'd2,
    KindDuplicate = 3'd3,
    KindBeyond    = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    StIdle,
    StFlush,
    StFollow,
    StDone
  } state_e;

  // Contents of one window slot.
  typedef struct packed {
    logic               valid;
    logic [HandleW-1:0] handle;
    logic [LenW-1:0]    length;
  } slot_t;

  // Control from the sequencer to the cell chain.
  typedef struct packed {
    logic               shift;
    logic               wr_en;
    logic [WinIdxW-1:0] wr_idx;
  } chain_ctrl_t;

  // One result as it waits in the pending and output registers.
  typedef struct packed {
    kind_e              kind;
    logic [SeqW-1:0]    seq;
    logic [HandleW-1:0] handle;
    logic [LenW-1:0]    length;
  } res_t;

endpackage

@@ sv/sro_if.sv @@
// Valid/ready channel interfaces for requests into and results out of the reorder buffer.
`timescale 1ns / 1ps

interface sro_in_if;
  logic                          valid;
  logic                          ready;
  sro_pkg::op_e                  operation;
  logic [sro_pkg::SeqW-1:0]      seq;
  logic [sro_pkg::HandleW-1:0]   handle;
  logic [sro_pkg::LenW-1:0]      length;

  modport source (output valid, operation, seq, handle, length, input ready);
  modport sink (input valid, operation, seq, handle, length, output ready);
endinterface

interface sro_out_if;
  logic                          valid;
  logic                          ready;
  sro_pkg::kind_e                kind;
  logic [sro_pkg::SeqW-1:0]      out_seq;
  logic [sro_pkg::HandleW-1:0]   out_handle;
  logic [sro_pkg::LenW-1:0]      out_length;
  logic                          last;

  modport source (output valid, kind, out_seq, out_handle, out_length, last, input ready);
  modport sink (input valid, kind, out_seq, out_handle, out_length, last, output ready);
endinterface

@@ sv/sro_cell.sv @@
// One window slot: holds a packet and takes its neighbor's contents on a shift.
`timescale 1ns / 1ps

module sro_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           shift_i,
  input  logic           wr_i,
  input  sro_pkg::slot_t next_i,
  input  sro_pkg::slot_t wr_data_i,
  output sro_pkg::slot_t slot_o
);
  import sro_pkg::*;

  logic               valid_q;
  logic [HandleW-1:0] handle_q;
  logic [LenW-1:0]    length_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= next_i.valid;
    end else if (wr_i) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      handle_q <= next_i.handle;
      length_q <= next_i.length;
    end else if (wr_i) begin
      handle_q <= wr_data_i.handle;
      length_q <= wr_data_i.length;
    end
  end

  assign slot_o = '{valid: valid_q, handle: handle_q, length: length_q};

endmodule

@@ sv/sro_chain.sv @@
// Row of window cells; cell 0 holds the packet right after the last delivered one.
`timescale 1ns / 1ps

module sro_chain (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sro_pkg::chain_ctrl_t         ctrl_i,
  input  sro_pkg::slot_t               wr_data_i,
  output sro_pkg::slot_t               head_o,
  output logic [sro_pkg::Window-1:0]   valid_o
);
  import sro_pkg::*;

  slot_t slots [Window];
  slot_t nexts [Window];

  for (genvar i = 0; i < Window; i++) begin : g_cell
    logic wr;

    // The last cell refills with an empty slot when the row moves up.
    if (i == Window - 1) begin : g_tail
      assign nexts[i] = '0;
    end else begin : g_body
      assign nexts[i] = slots[i+1];
    end

    assign wr = ctrl_i.wr_en && (ctrl_i.wr_idx == WinIdxW'(i));

    sro_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .shift_i   (ctrl_i.shift),
      .wr_i      (wr),
      .next_i    (nexts[i]),
      .wr_data_i (wr_data_i),
      .slot_o    (slots[i])
    );

    assign valid_o[i] = slots[i].valid;
  end

  assign head_o = slots[0];

endmodule

@@ sv/sequence_reorder_buffer_unit.sv @@
// Top level of the sequence reorder buffer: sequencer, result registers and the cell row.
`timescale 1ns / 1ps

// The block puts packets that arrive over several links back into sequence order.
// Each add request carries a wrapping 16-bit sequence number, a buffer handle and
// a length. A packet that is outdated (at or behind the last delivered number, by
// the half-space rule), a duplicate, or more than Window ahead is dropped with one
// status result. A packet that is next in line is delivered at once together with
// every held packet that follows it without a gap; any other packet is held in the
// window and one status result asks the surroundings to arm a timeout. A timeout
// request releases the held packets up to its sequence number, skipping empty
// slots, and then the contiguous followers; a target beyond the furthest held
// packet gives no result. The flag last marks the final result of each request.
// Timing: a request is taken only while the sequencer is idle, and the cell row
// moves up by one slot per cycle while the output register has room. From one
// taken request to the next, a request that gives a status result passes
// through the done state, an in-order add through the follow and done states
// with one retire step per delivered packet, and a timeout in range through the
// flush, follow and done states with one step per retired slot. A timeout whose
// target lies beyond the furthest held packet frees the input in the next cycle.
// The sequencer stalls while the output register is full and not taken. The result
// register lets the next request in while the final result still waits to be
// taken. Slots need no clearing pass after reset; only their valid bits are reset.
module sequence_reorder_buffer_unit (
  input  logic clk_i,
  input  logic rst_ni,
  sro_in_if.sink    in_i,
  sro_out_if.source out_o
);
  import sro_pkg::*;

  state_e             state_q, state_d;
  logic [SeqW-1:0]    exp_last_q, exp_last_d;
  logic [SpanW-1:0]   span_q, span_d;
  logic [SpanW-1:0]   cnt_q, cnt_d;

  res_t               pend_q;
  logic               pend_valid_q, pend_valid_d;
  res_t               out_q;
  logic               out_last_q;
  logic               out_valid_q, out_valid_d;

  chain_ctrl_t        chain_ctrl;
  slot_t              wr_data;
  slot_t              head;
  logic [Window-1:0]  slot_valid;

  logic               in_fire;
  logic               out_free;
  logic [SeqW-1:0]    delta;
  logic [WinIdxW-1:0] add_idx;
  logic               outdated;
  logic               beyond;
  logic               dup;
  logic               add_store;
  logic               add_inorder;
  logic               flush_oor;
  logic               follow_more;
  logic               step;
  logic               produce;
  logic               load_mid;
  logic               load_fin;
  kind_e              status_kind;

  // Distance of the request's number from the last delivered one, modulo the space.
  assign delta   = in_i.seq - exp_last_q;
  assign add_idx = WinIdxW'(delta - SeqW'(1));

  // A distance of zero or in the upper half of the space is behind us.
  assign outdated    = (delta == '0) || delta[SeqW-1];
  assign beyond      = delta > SeqW'(Window);
  assign dup         = slot_valid[add_idx];
  assign add_store   = !outdated && !beyond && !dup;
  assign add_inorder = add_store && (delta == SeqW'(1));
  assign flush_oor   = delta > SeqW'(span_q);

  assign in_i.ready  = (state_q == StIdle);
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;
  assign follow_more = (span_q != '0) && head.valid;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (in_i.operation == OpAdd) begin
            state_d = add_inorder ? StFollow : StDone;
          end else if (!flush_oor) begin
            state_d = StFlush;
          end
        end
      end
      StFlush: begin
        if (cnt_q == '0) begin
          state_d = StFollow;
        end
      end
      StFollow: begin
        if (!follow_more) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (!pend_valid_q || out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Sequencer outputs. A retire step moves the cell row up by one slot; it waits
  // for room in the result register so that a delivered packet is never lost.
  always_comb begin
    step = 1'b0;
    case (state_q)
      StFlush:  step = out_free && (cnt_q != '0);
      StFollow: step = out_free && follow_more;
      default:  step = 1'b0;
    endcase
    produce  = step && head.valid;
    load_mid = produce && pend_valid_q;
    load_fin = (state_q == StDone) && pend_valid_q && out_free;

    chain_ctrl.shift  = step;
    chain_ctrl.wr_en  = in_fire && (in_i.operation == OpAdd) && add_store;
    chain_ctrl.wr_idx = add_idx;

    if (outdated) begin
      status_kind = KindOutdated;
    end else if (beyond) begin
      status_kind = KindBeyond;
    end else if (dup) begin
      status_kind = KindDuplicate;
    end else begin
      status_kind = KindHeld;
    end
  end

  assign wr_data = '{valid: 1'b1, handle: in_i.handle, length: in_i.length};

  // Window bookkeeping.
  always_comb begin
    exp_last_d = step ? exp_last_q + SeqW'(1) : exp_last_q;

    span_d = span_q;
    if (chain_ctrl.wr_en) begin
      if (delta > SeqW'(span_q)) begin
        span_d = SpanW'(delta);
      end
    end else if (step && (span_q != '0)) begin
      span_d = span_q - SpanW'(1);
    end

    cnt_d = cnt_q;
    if (in_fire && (in_i.operation == OpTimeout)) begin
      cnt_d = SpanW'(delta);
    end else if (step && (state_q == StFlush)) begin
      cnt_d = cnt_q - SpanW'(1);
    end
  end

  // The pending register holds the newest result until it is known whether
  // another one follows, which decides its last flag.
  always_comb begin
    pend_valid_d = pend_valid_q;
    if (produce) begin
      pend_valid_d = 1'b1;
    end else if (in_fire && (in_i.operation == OpAdd) && !add_inorder) begin
      pend_valid_d = 1'b1;
    end else if (load_fin) begin
      pend_valid_d = 1'b0;
    end

    if (load_mid || load_fin) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      exp_last_q   <= '0;
      span_q       <= '0;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      exp_last_q   <= exp_last_d;
      span_q       <= span_d;
      cnt_q        <= cnt_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (produce) begin
      pend_q <= '{kind: KindDeliver, seq: exp_last_q + SeqW'(1),
                  handle: head.handle, length: head.length};
    end else if (in_fire && (in_i.operation == OpAdd)) begin
      pend_q <= '{kind: status_kind, seq: in_i.seq,
                  handle: in_i.handle, length: in_i.length};
    end

    if (load_mid || load_fin) begin
      out_q      <= pend_q;
      out_last_q <= load_fin;
    end
  end

  sro_chain u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (chain_ctrl),
    .wr_data_i (wr_data),
    .head_o    (head),
    .valid_o   (slot_valid)
  );

  assign out_o.valid      = out_valid_q;
  assign out_o.kind       = out_q.kind;
  assign out_o.out_seq    = out_q.seq;
  assign out_o.out_handle = out_q.handle;
  assign out_o.out_length = out_q.length;
  assign out_o.last       = out_last_q;

endmodule
